FILE: hdl/ukol_pkg.sv
// ukol_pkg: shared types, codes and widths for the unique key ordered list
// used by ukol_cell and unique_key_ordered_list_top; no dependencies
package ukol_pkg;

    localparam int KEY_W       = 32;
    localparam int PAYLOAD_W   = 32;
    localparam int POS_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int FIDX_W      = 4;
    localparam int ECOUNT_W    = 5;

    localparam int DEFAULT_CAPACITY = 16;

    // request codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;

    // broadcast from the control to every cell
    typedef struct packed {
        logic                        do_insert;
        logic signed [KEY_W-1:0]     new_key;
        logic        [PAYLOAD_W-1:0] new_payload;
        logic        [POS_W-1:0]     pos;
    } cell_cmd_t;

endpackage

FILE: hdl/ukol_cell.sv
// ukol_cell: one list slot holding a key and payload, compares against the
// broadcast key and shifts in from its lower neighbor; depends on ukol_pkg
module ukol_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                                 aclk,
    input  ukol_pkg::cell_cmd_t                  cmd,
    input  logic                                 occupied,
    input  logic signed [ukol_pkg::KEY_W-1:0]    prev_key,
    input  logic        [ukol_pkg::PAYLOAD_W-1:0] prev_payload,
    output logic signed [ukol_pkg::KEY_W-1:0]    key_out,
    output logic        [ukol_pkg::PAYLOAD_W-1:0] payload_out,
    output logic                                 hit
);

    logic signed [ukol_pkg::KEY_W-1:0]     key_reg;
    logic        [ukol_pkg::PAYLOAD_W-1:0] payload_reg;
    logic                                  at_pos;
    logic                                  above_pos;

    assign at_pos    = (CELL_IDX == int'(cmd.pos));
    assign above_pos = (CELL_IDX >  int'(cmd.pos));

    // only slots below the count take part in the search
    assign hit = occupied && (key_reg == cmd.new_key);

    always_ff @(posedge aclk) begin
        if (cmd.do_insert) begin
            if (at_pos) begin
                key_reg     <= cmd.new_key;
                payload_reg <= cmd.new_payload;
            end else if (above_pos) begin
                key_reg     <= prev_key;
                payload_reg <= prev_payload;
            end
        end
    end

    assign key_out     = key_reg;
    assign payload_out = payload_reg;

endmodule

FILE: hdl/unique_key_ordered_list_top.sv
// unique_key_ordered_list_top: bounded ordered list of unique keys built as
// a row of ukol_cell slots plus insert/search control; depends on ukol_pkg
//
//  channel | direction | ports
//  --------+-----------+------------------------------------------------------
//  request | in        | s_valid s_ready s_opcode s_entry_key s_entry_payload
//          |           | s_insert_position
//  result  | out       | m_valid m_ready m_status m_found m_found_index
//          |           | m_entry_count
//
// one request per cycle unless stalled: every cell compares its key with the
// request key in the cycle of the transfer, and an insert shifts all cells
// above the position at that edge, so the next request sees the updated list
// result is held in an output register; a new request is taken whenever that
// register is empty or its result is being taken in the same cycle
// aresetn (synchronous, active low) clears the count and the output valid;
// cell contents are not reset and are only read below the count
module unique_key_ordered_list_top #(
    parameter int CAPACITY = ukol_pkg::DEFAULT_CAPACITY
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // request channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_opcode,
    input  logic signed [ukol_pkg::KEY_W-1:0]      s_entry_key,
    input  logic        [ukol_pkg::PAYLOAD_W-1:0]  s_entry_payload,
    input  logic        [ukol_pkg::POS_W-1:0]      s_insert_position,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic        [ukol_pkg::STATUS_W-1:0]   m_status,
    output logic                                   m_found,
    output logic        [ukol_pkg::FIDX_W-1:0]     m_found_index,
    output logic        [ukol_pkg::ECOUNT_W-1:0]   m_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // list state
    logic [CNT_W-1:0] count_reg, count_next;

    // output register
    logic                             m_valid_reg, m_valid_next;
    logic [ukol_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic                             found_reg, found_next;
    logic [ukol_pkg::FIDX_W-1:0]      fidx_reg, fidx_next;
    logic [ukol_pkg::ECOUNT_W-1:0]    ecount_reg, ecount_next;

    // cell row wiring
    ukol_pkg::cell_cmd_t                  cmd;
    logic signed [ukol_pkg::KEY_W-1:0]    cell_key [CAPACITY];
    logic        [ukol_pkg::PAYLOAD_W-1:0] cell_payload [CAPACITY];
    logic        [CAPACITY-1:0]           cell_hit;

    logic             transfer_in;
    logic             any_hit;
    logic [IDX_W-1:0] first_idx;
    logic             bad_pos;
    logic             is_insert;

    // take a request when the output register is free or being drained
    assign s_ready     = !m_valid_reg || m_ready;
    assign transfer_in = s_valid && s_ready;
    assign is_insert   = (s_opcode == ukol_pkg::OP_INSERT);

    // position past the end, or no room left
    assign bad_pos = (int'(s_insert_position) > int'(count_reg)) ||
                     (int'(count_reg) == CAPACITY);

    assign cmd.do_insert   = transfer_in && is_insert && !bad_pos && !any_hit;
    assign cmd.new_key     = s_entry_key;
    assign cmd.new_payload = s_entry_payload;
    assign cmd.pos         = s_insert_position;

    // row of cells, each above the first fed by its lower neighbor
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            ukol_cell #(
                .CELL_IDX (i)
            ) u_cell (
                .aclk         (aclk),
                .cmd          (cmd),
                .occupied     (int'(count_reg) > i),
                .prev_key     (s_entry_key),
                .prev_payload (s_entry_payload),
                .key_out      (cell_key[i]),
                .payload_out  (cell_payload[i]),
                .hit          (cell_hit[i])
            );
        end else begin : g_rest
            ukol_cell #(
                .CELL_IDX (i)
            ) u_cell (
                .aclk         (aclk),
                .cmd          (cmd),
                .occupied     (int'(count_reg) > i),
                .prev_key     (cell_key[i-1]),
                .prev_payload (cell_payload[i-1]),
                .key_out      (cell_key[i]),
                .payload_out  (cell_payload[i]),
                .hit          (cell_hit[i])
            );
        end
    end

    // lowest matching slot
    assign any_hit = |cell_hit;

    always_comb begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (cell_hit[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    // next list count
    always_comb begin
        count_next = count_reg;
        if (cmd.do_insert) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
    end

    // result formation
    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        ecount_next  = ecount_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (transfer_in) begin
            m_valid_next = 1'b1;
            found_next   = 1'b0;
            fidx_next    = '0;
            ecount_next  = ukol_pkg::ECOUNT_W'(count_next);
            priority if (!is_insert) begin
                status_next = ukol_pkg::ST_OK;
                found_next  = any_hit;
                fidx_next   = any_hit ? ukol_pkg::FIDX_W'(first_idx) : '0;
            end else if (bad_pos) begin
                status_next = ukol_pkg::ST_BAD_POS;
            end else if (any_hit) begin
                status_next = ukol_pkg::ST_DUP;
            end else begin
                status_next = ukol_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
        ecount_reg <= ecount_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_found       = found_reg;
    assign m_found_index = fidx_reg;
    assign m_entry_count = ecount_reg;

endmodule

FILE: test/testbench.sv
// testbench: self-checking bench for unique_key_ordered_list_top, with a small list tracker
// class that predicts each result and random valid/ready traffic on both channels
// depends on ukol_pkg and unique_key_ordered_list_top
`timescale 1ns / 1ps

module testbench;
    import ukol_pkg::*;

    localparam int CAPACITY       = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int CALM_ITEMS     = 150;   // last random items run with no idling
    localparam int HOLD_AT_ITEM   = 500;   // where the long receiver hold-off starts
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES   = 8;

    // one expected result, fields at the port widths
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [FIDX_W-1:0]   index;
        logic [ECOUNT_W-1:0] count;
    } list_result_t;

    // tracks the list contents and the results still owed by the block
    class ordered_list_scoreboard;
        logic signed [KEY_W-1:0] keys [CAPACITY];
        logic [PAYLOAD_W-1:0]    payloads [CAPACITY];
        int                      stored = 0;
        int                      errors = 0;
        list_result_t            owed_results [$];

        // lowest stored position holding key
        function bit find_key(input logic signed [KEY_W-1:0] key, output int where);
            where = 0;
            for (int i = 0; i < stored; i++) begin
                if (keys[i] == key) begin
                    where = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // update the list for one accepted request and queue its result
        function void apply_request(input logic op, input logic signed [KEY_W-1:0] key,
                                    input logic [PAYLOAD_W-1:0] payload,
                                    input logic [POS_W-1:0] pos);
            list_result_t res;
            int           where;
            bit           hit;
            hit = find_key(key, where);
            res = '0;
            if (op == OP_SEARCH) begin
                res.found = hit;
                res.index = hit ? FIDX_W'(where) : '0;
            end else if (int'(pos) > stored || stored >= CAPACITY) begin
                res.status = ST_BAD_POS;
            end else if (hit) begin
                res.status = ST_DUP;
            end else begin
                for (int j = stored; j > int'(pos); j--) begin
                    keys[j]     = keys[j-1];
                    payloads[j] = payloads[j-1];
                end
                keys[int'(pos)]     = key;
                payloads[int'(pos)] = payload;
                stored++;
            end
            res.count = ECOUNT_W'(stored);
            owed_results.push_back(res);
        endfunction

        function void report(input string field, input int expected, input int actual);
            $display("%0t: mismatch on %s: expected %0d, actual %0d",
                     $time, field, expected, actual);
            errors++;
        endfunction

        // compare one result from the block with the oldest owed result
        function void check_result(input logic [STATUS_W-1:0] status, input logic found,
                                   input logic [FIDX_W-1:0] index,
                                   input logic [ECOUNT_W-1:0] count);
            list_result_t exp_res;
            if (owed_results.size() == 0) begin
                $display("%0t: result with nothing owed: expected none, actual status %0d",
                         $time, status);
                errors++;
                return;
            end
            exp_res = owed_results.pop_front();
            if (status !== exp_res.status)
                report("status", int'(exp_res.status), int'(status));
            if (found !== exp_res.found)
                report("found", int'(exp_res.found), int'(found));
            if (index !== exp_res.index)
                report("found_index", int'(exp_res.index), int'(index));
            if (count !== exp_res.count)
                report("entry_count", int'(exp_res.count), int'(count));
        endfunction
    endclass

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #4 aclk = ~aclk;

    // request channel
    logic                       s_valid           = 1'b0;
    logic                       s_ready;
    logic                       s_opcode          = OP_INSERT;
    logic signed [KEY_W-1:0]    s_entry_key       = '0;
    logic        [PAYLOAD_W-1:0] s_entry_payload  = '0;
    logic        [POS_W-1:0]    s_insert_position = '0;

    // result channel
    logic                       m_valid;
    logic                       m_ready           = 1'b0;
    logic        [STATUS_W-1:0] m_status;
    logic                       m_found;
    logic        [FIDX_W-1:0]   m_found_index;
    logic        [ECOUNT_W-1:0] m_entry_count;

    ordered_list_scoreboard sb;

    bit calm         = 1'b0;  // no idling on either side
    bit hold_request = 1'b0;  // asks the receiver for one long hold-off
    int idle_cycles  = 0;

    unique_key_ordered_list_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_entry_key       (s_entry_key),
        .s_entry_payload   (s_entry_payload),
        .s_insert_position (s_insert_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_found           (m_found),
        .m_found_index     (m_found_index),
        .m_entry_count     (m_entry_count)
    );

    // offer one request and hold it until the transfer; inputs change only
    // by nonblocking assignment right after a rising edge, and handshakes are
    // sampled right after the edge, so both sides see pre-edge values
    task automatic send_request(input logic op, input logic signed [KEY_W-1:0] key,
                                input logic [PAYLOAD_W-1:0] payload,
                                input logic [POS_W-1:0] pos);
        s_valid           <= 1'b1;
        s_opcode          <= op;
        s_entry_key       <= key;
        s_entry_payload   <= payload;
        s_insert_position <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // transfer happened at this edge: update the tracker before the next item
        sb.apply_request(op, key, payload, pos);
        if (!calm && $urandom_range(0, 7) == 0) begin
            // sender gap, with junk on the payload ports while valid is low
            s_valid           <= 1'b0;
            s_opcode          <= 1'($urandom_range(0, 1));
            s_entry_key       <= $urandom;
            s_entry_payload   <= $urandom;
            s_insert_position <= POS_W'($urandom_range(0, 31));
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // a key not in the list: mostly full range, sometimes near zero
    function automatic logic signed [KEY_W-1:0] fresh_key();
        logic signed [KEY_W-1:0] k;
        int                      where;
        do begin
            if ($urandom_range(0, 3) == 0) begin
                k = $urandom_range(0, 32);
                k = k - 16;
            end else begin
                k = $urandom;
            end
        end while (sb.find_key(k, where));
        return k;
    endfunction

    function automatic logic signed [KEY_W-1:0] stored_key();
        return sb.keys[$urandom_range(0, sb.stored - 1)];
    endfunction

    // fill slowly so most of the run sees a partly filled list, and the
    // late part sees it full
    task automatic random_request();
        int                      r;
        int                      n;
        logic signed [KEY_W-1:0] key;
        r = $urandom_range(0, 99);
        n = sb.stored;
        if (r < 2 && n < CAPACITY) begin
            // good insert: fresh key at any legal position
            send_request(OP_INSERT, fresh_key(), $urandom, POS_W'($urandom_range(0, n)));
        end else if (r < 45) begin
            // search for a stored key, absent when the list is empty
            key = (n > 0) ? stored_key() : fresh_key();
            send_request(OP_SEARCH, key, $urandom, POS_W'($urandom_range(0, 31)));
        end else if (r < 60) begin
            send_request(OP_SEARCH, fresh_key(), $urandom, POS_W'($urandom_range(0, 31)));
        end else if (r < 75 && n > 0) begin
            // duplicate key at a legal position (or any position when full)
            send_request(OP_INSERT, stored_key(), $urandom,
                         (n < CAPACITY) ? POS_W'($urandom_range(0, n))
                                        : POS_W'($urandom_range(0, 31)));
        end else if (r < 90) begin
            // position past the count, key stored or fresh
            key = (n > 0 && $urandom_range(0, 1) == 0) ? stored_key() : fresh_key();
            send_request(OP_INSERT, key, $urandom, POS_W'($urandom_range(n + 1, 31)));
        end else begin
            send_request(1'($urandom_range(0, 1)), $urandom, $urandom,
                         POS_W'($urandom_range(0, 31)));
        end
    endtask

    // stimulus
    initial begin
        sb = new;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list, bad positions, inserts at front, middle, end
        send_request(OP_SEARCH, 32'sd0, 32'h0, 5'd0);
        send_request(OP_INSERT, 32'sd5, 32'h1, 5'd1);
        send_request(OP_INSERT, 32'sh8000_0000, 32'h2, 5'd31);
        send_request(OP_INSERT, 32'sh8000_0000, 32'h0000_0000, 5'd0);
        send_request(OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff, 5'd1);
        send_request(OP_INSERT, -32'sd1, 32'h5a5a_a5a5, 5'd0);
        send_request(OP_INSERT, 32'sd0, 32'ha5a5_5a5a, 5'd1);
        // duplicate key, then a duplicate at a bad position (position wins)
        send_request(OP_INSERT, 32'sh7fff_ffff, 32'h3, 5'd0);
        send_request(OP_INSERT, 32'sh7fff_ffff, 32'h4, 5'd10);
        send_request(OP_INSERT, -32'sd1, 32'h5, 5'd4);
        // searches hitting every position, and a miss
        send_request(OP_SEARCH, 32'sh7fff_ffff, 32'h0, 5'd0);
        send_request(OP_SEARCH, 32'sh8000_0000, 32'h0, 5'd0);
        send_request(OP_SEARCH, -32'sd1, 32'h0, 5'd0);
        send_request(OP_SEARCH, 32'sd0, 32'h0, 5'd0);
        send_request(OP_SEARCH, 32'sd1, 32'hffff_ffff, 5'd31);

        // random part
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == HOLD_AT_ITEM) hold_request = 1'b1;
            if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            random_request();
        end

        // make sure the full list is seen: top up, then insert into it
        while (sb.stored < CAPACITY) begin
            send_request(OP_INSERT, fresh_key(), $urandom,
                         POS_W'($urandom_range(0, sb.stored)));
        end
        send_request(OP_INSERT, fresh_key(), $urandom, 5'd0);
        send_request(OP_INSERT, fresh_key(), $urandom, 5'(CAPACITY));
        send_request(OP_INSERT, sb.keys[0], $urandom, 5'd0);
        send_request(OP_SEARCH, sb.keys[CAPACITY-1], $urandom, 5'd0);
        send_request(OP_SEARCH, sb.keys[0], $urandom, 5'd0);
        s_valid <= 1'b0;

        // wait out the owed results; the watchdog covers a hang
        while (sb.owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // receiver: checks each result transfer, stalls in random bursts and
    // once for a long hold-off so the block fills and blocks its input
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_status, m_found, m_found_index, m_entry_count);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                // start a stall burst with this cycle
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run when no transfer happens for too long
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule

FILE: sim.f
hdl/ukol_pkg.sv
hdl/ukol_cell.sv
hdl/unique_key_ordered_list_top.sv
test/testbench.sv
